### rtl/button_press_duration_classifier_unit_assert.svh
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BPDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BPDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bpdc_pkg.sv
package bpdc_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned ThreshW = 16;
  localparam int unsigned ButtonW = 8;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CodeW-1:0] {
    EV_NONE       = 3'd0,
    EV_SHORT      = 3'd1,
    EV_LONG1_REL  = 3'd2,
    EV_LONG2_REL  = 3'd3,
    EV_LONG1_HOLD = 3'd4,
    EV_LONG2_HOLD = 3'd5
  } ev_code_t;

  localparam logic [IdxW-1:0] CFG_DEBOUNCE = 3'd0;
  localparam logic [IdxW-1:0] CFG_SHORT    = 3'd1;
  localparam logic [IdxW-1:0] CFG_LONG1    = 3'd2;
  localparam logic [IdxW-1:0] CFG_LONG2    = 3'd3;
  localparam logic [IdxW-1:0] CFG_POLARITY = 3'd4;
  localparam logic [IdxW-1:0] CFG_BUTTON   = 3'd5;

  localparam logic [ThreshW-1:0] RST_DEBOUNCE = 16'd50;
  localparam logic [ThreshW-1:0] RST_SHORT    = 16'd50;
  localparam logic [ThreshW-1:0] RST_LONG1    = 16'd1000;
  localparam logic [ThreshW-1:0] RST_LONG2    = 16'd3000;
  localparam logic               RST_PRESSED  = 1'b0;
  localparam logic [ButtonW-1:0] RST_BUTTON   = 8'd0;
  localparam logic               RST_LAST_LVL = 1'b1;

  typedef struct packed {
    logic [ThreshW-1:0] debounce_ms;
    logic [ThreshW-1:0] short_ms;
    logic [ThreshW-1:0] long1_ms;
    logic [ThreshW-1:0] long2_ms;
    logic               pressed_level;
    logic [ButtonW-1:0] button_number;
  } cfg_t;

  typedef struct packed {
    logic             pin_level;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    ev_code_t           event_code;
    logic [ButtonW-1:0] event_button;
  } result_t;

  typedef struct packed {
    logic hold1_reported;
    logic hold2_reported;
  } status_t;

endpackage

### rtl/bpdc_cfg_regs.sv
module bpdc_cfg_regs
  import bpdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [IdxW-1:0]     cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: cfg_nxt.debounce_ms   = cfg_wdata;
        CFG_SHORT:    cfg_nxt.short_ms      = cfg_wdata;
        CFG_LONG1:    cfg_nxt.long1_ms      = cfg_wdata;
        CFG_LONG2:    cfg_nxt.long2_ms      = cfg_wdata;
        CFG_POLARITY: cfg_nxt.pressed_level = cfg_wdata[0];
        CFG_BUTTON:   cfg_nxt.button_number = cfg_wdata[ButtonW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= RST_DEBOUNCE;
      cfg_r.short_ms      <= RST_SHORT;
      cfg_r.long1_ms      <= RST_LONG1;
      cfg_r.long2_ms      <= RST_LONG2;
      cfg_r.pressed_level <= RST_PRESSED;
      cfg_r.button_number <= RST_BUTTON;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/bpdc_classify.sv
module bpdc_classify
  import bpdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    adv,
  input  item_t   item,
  output result_t res,
  output status_t sts
);

  logic [TimeW-1:0] press_start_r;
  logic [TimeW-1:0] press_start_nxt;
  logic             last_level_r;
  logic             last_level_nxt;
  logic             hold1_r;
  logic             hold1_nxt;
  logic             hold2_r;
  logic             hold2_nxt;

  logic [TimeW-1:0] held;
  logic             ge_short;
  logic             ge_long1;
  logic             ge_long2;
  logic             gt_deb;
  logic             band1;
  ev_code_t         ev;

  assign held     = item.now_ms - press_start_r;
  assign ge_short = held >= TimeW'(cfg.short_ms);
  assign ge_long1 = held >= TimeW'(cfg.long1_ms);
  assign ge_long2 = held >= TimeW'(cfg.long2_ms);
  assign gt_deb   = held >  TimeW'(cfg.debounce_ms);
  assign band1    = ge_long1 && !ge_long2;

  always_comb begin
    press_start_nxt = press_start_r;
    last_level_nxt  = last_level_r;
    hold1_nxt       = hold1_r;
    hold2_nxt       = hold2_r;
    ev              = EV_NONE;
    if (item.pin_level == last_level_r) begin
      if (item.pin_level == cfg.pressed_level) begin
        priority if (band1 && !hold1_r) begin
          hold1_nxt = 1'b1;
          ev        = EV_LONG1_HOLD;
        end else if (ge_long2 && !hold2_r) begin
          hold2_nxt = 1'b1;
          ev        = EV_LONG2_HOLD;
        end else begin
          ev = EV_NONE;
        end
      end
    end else begin
      last_level_nxt = item.pin_level;
      if (item.pin_level == cfg.pressed_level) begin
        press_start_nxt = item.now_ms;
      end else if (gt_deb) begin
        priority if (ge_short && !ge_long1) begin
          ev = EV_SHORT;
        end else if (band1) begin
          hold1_nxt = 1'b0;
          hold2_nxt = 1'b0;
          ev        = EV_LONG1_REL;
        end else if (ge_long2) begin
          hold1_nxt = 1'b0;
          hold2_nxt = 1'b0;
          ev        = EV_LONG2_REL;
        end else begin
          ev = EV_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_start_r <= '0;
      last_level_r  <= RST_LAST_LVL;
      hold1_r       <= 1'b0;
      hold2_r       <= 1'b0;
    end else if (adv) begin
      press_start_r <= press_start_nxt;
      last_level_r  <= last_level_nxt;
      hold1_r       <= hold1_nxt;
      hold2_r       <= hold2_nxt;
    end
  end

  assign res.event_code     = ev;
  assign res.event_button   = cfg.button_number;
  assign sts.hold1_reported = hold1_r;
  assign sts.hold2_reported = hold2_r;

endmodule

### rtl/button_press_duration_classifier_unit.sv
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------------
// in       | in_valid/in_stall  | in_pin_level, in_now_ms
// out      | out_valid/out_stall| out_event_code, out_event_button
// cfg      | cfg_wr_en          | cfg_index, cfg_wdata
//
// One item per cycle sustained while out_stall is low; an accepted item is
// held in the input stage (item_r), then enters res_r and raises out_valid.
// The classifier state advances as an item enters the result register.
// Synchronous active-low reset restores register defaults and press state.
// A stalled result holds; a new item is still taken while the input stage is empty.
module button_press_duration_classifier_unit
  import bpdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_pin_level,
  input  logic [TimeW-1:0]    in_now_ms,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CodeW-1:0]    out_event_code,
  output logic [ButtonW-1:0]  out_event_button,
  input  logic                cfg_wr_en,
  input  logic [IdxW-1:0]     cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

`include "button_press_duration_classifier_unit_assert.svh"

  cfg_t    cfg;
  item_t   item_r;
  logic    in_vld_r;
  logic    in_vld_nxt;
  logic    out_vld_r;
  logic    out_vld_nxt;
  result_t res_r;
  result_t res_c;
  status_t sts;
  logic    in_acc;
  logic    adv;

  bpdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bpdc_classify u_cls (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .adv   (adv),
    .item  (item_r),
    .res   (res_c),
    .sts   (sts)
  );

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && out_vld_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // hold payload unless a new item moves in, and the result unless adv
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.pin_level <= in_pin_level;
      item_r.now_ms    <= in_now_ms;
    end
    if (adv) begin
      res_r <= res_c;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_event_code   = res_r.event_code;
  assign out_event_button = res_r.event_button;

  `BPDC_ASSERT_NEXT(a_adv_fills_out, adv, out_vld_r, "advanced item missing at output")
  `BPDC_ASSERT_NEXT(a_hold1_sets, adv && (res_c.event_code == EV_LONG1_HOLD),
                    sts.hold1_reported, "long1 hold flag not set")
  `BPDC_ASSERT_NEXT(a_long_rel_clears,
                    adv && ((res_c.event_code == EV_LONG1_REL) ||
                            (res_c.event_code == EV_LONG2_REL)),
                    !sts.hold1_reported && !sts.hold2_reported,
                    "hold flags not cleared on long release")
  `BPDC_ASSERT_NOW(a_hold2_once, adv && sts.hold2_reported,
                   res_c.event_code != EV_LONG2_HOLD, "long2 hold reported twice")

endmodule
